// File: rtl/core/ald_pkg.sv
// shared types and constants of the audio level detector
package ald_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 16;
  localparam int ACC_W    = 24;
  localparam int CFC_W    = 8;
  localparam int LEVEL_W  = 10;
  localparam int THR_W    = 10;
  localparam int PROD_W   = 23;
  localparam int DVS_W    = 16;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_CAP = 10'd1000;
  localparam logic [6:0]         PCT_SCALE = 7'd100;

  localparam logic [THR_W-1:0] ON_THR_RST    = 10'd20;
  localparam logic [THR_W-1:0] OFF_THR_RST   = 10'd10;
  localparam logic [CFC_W-1:0] CALIB_LEN_RST = 8'd50;

  // register index (word address)
  localparam logic [1:0] REG_ON_THR    = 2'd0;
  localparam logic [1:0] REG_OFF_THR   = 2'd1;
  localparam logic [1:0] REG_CALIB_LEN = 2'd2;

  typedef enum logic [1:0] {
    DIV_MEAN  = 2'd0,
    DIV_FLOOR = 2'd1,
    DIV_LEVEL = 2'd2
  } div_sel_t;

  typedef enum logic [10:0] {
    S_IDLE        = 11'b000_0000_0001,
    S_MEAN        = 11'b000_0000_0010,
    S_MEAN_WAIT   = 11'b000_0000_0100,
    S_CAL         = 11'b000_0000_1000,
    S_CAL_CHK     = 11'b000_0001_0000,
    S_FLOOR_WAIT  = 11'b000_0010_0000,
    S_SCALE       = 11'b000_0100_0000,
    S_LEVEL_START = 11'b000_1000_0000,
    S_LEVEL_WAIT  = 11'b001_0000_0000,
    S_HYST        = 11'b010_0000_0000,
    S_DONE        = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     clear_frame;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_mean;
    logic     cal_update;
    logic     latch_floor;
    logic     latch_prod;
    logic     latch_level;
    logic     update_ind;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cal_done;
    logic cal_reached;
    logic mean_gt_floor;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// File: rtl/core/ald_divider.sv
// iterative restoring divider, one quotient bit per cycle
module ald_divider #(
  parameter int DIV_W = 25,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    priority if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(DIV_W);
    end else if (step_r != '0) begin
      rem_nxt  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      done_nxt = (step_r == STEP_W'(1));
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/ald_ctrl.sv
// frame-end sequencer of the audio level detector
module ald_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_frame_last,
  output logic              in_stall,
  input  ald_pkg::ctrl_sts_t sts,
  output ald_pkg::ctrl_cmd_t cmd
);

  ald_pkg::state_t state_r, state_nxt;

  assign in_stall = (state_r != ald_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = ald_pkg::DIV_MEAN;
    unique case (state_r)
      ald_pkg::S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_frame_last) state_nxt = ald_pkg::S_MEAN;
      end
      ald_pkg::S_MEAN: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel     = ald_pkg::DIV_MEAN;
        cmd.clear_frame = 1'b1;
        state_nxt       = ald_pkg::S_MEAN_WAIT;
      end
      ald_pkg::S_MEAN_WAIT: begin
        if (sts.div_done) begin
          cmd.latch_mean = 1'b1;
          state_nxt = sts.cal_done ? ald_pkg::S_SCALE : ald_pkg::S_CAL;
        end
      end
      ald_pkg::S_CAL: begin
        cmd.cal_update = 1'b1;
        state_nxt      = ald_pkg::S_CAL_CHK;
      end
      ald_pkg::S_CAL_CHK: begin
        if (sts.cal_reached) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = ald_pkg::DIV_FLOOR;
          state_nxt     = ald_pkg::S_FLOOR_WAIT;
        end else begin
          state_nxt = ald_pkg::S_DONE;
        end
      end
      ald_pkg::S_FLOOR_WAIT: begin
        if (sts.div_done) begin
          cmd.latch_floor = 1'b1;
          state_nxt       = ald_pkg::S_DONE;
        end
      end
      ald_pkg::S_SCALE: begin
        cmd.latch_prod = 1'b1;
        state_nxt = sts.mean_gt_floor ? ald_pkg::S_LEVEL_START : ald_pkg::S_HYST;
      end
      ald_pkg::S_LEVEL_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ald_pkg::DIV_LEVEL;
        state_nxt     = ald_pkg::S_LEVEL_WAIT;
      end
      ald_pkg::S_LEVEL_WAIT: begin
        if (sts.div_done) begin
          cmd.latch_level = 1'b1;
          state_nxt       = ald_pkg::S_HYST;
        end
      end
      ald_pkg::S_HYST: begin
        cmd.update_ind = 1'b1;
        state_nxt      = ald_pkg::S_DONE;
      end
      ald_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ald_pkg::S_IDLE;
        end
      end
      default: state_nxt = ald_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ald_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/ald_datapath.sv
// accumulators, calibration state, shared divider and result register
module ald_datapath #(
  parameter int MAX_FRAME_SAMPLES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ald_pkg::ctrl_cmd_t            cmd,
  output ald_pkg::ctrl_sts_t            sts,
  input  logic signed [ald_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [ald_pkg::THR_W-1:0]     on_thr,
  input  logic [ald_pkg::THR_W-1:0]     off_thr,
  input  logic [ald_pkg::CFC_W-1:0]     calib_len,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [ald_pkg::LEVEL_W-1:0]   out_level_percent,
  output logic                          out_indicator_on,
  output logic                          out_calibrating,
  output logic [ald_pkg::MEAN_W-1:0]    out_noise_level
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = CNT_W + ald_pkg::SAMPLE_W - 1;
  localparam int DIV_W = (SUM_W > ald_pkg::ACC_W) ? SUM_W : ald_pkg::ACC_W;
  localparam int DVS_W = ald_pkg::DVS_W;

  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [ald_pkg::MEAN_W-1:0]   mean_r;
  logic [ald_pkg::ACC_W-1:0]    nacc_r, nacc_nxt;
  logic [ald_pkg::CFC_W-1:0]    cfc_r, cfc_nxt;
  logic [ald_pkg::MEAN_W-1:0]   floor_r, floor_nxt;
  logic                         cal_done_r, cal_done_nxt;
  logic                         ind_r, ind_nxt;
  logic [ald_pkg::PROD_W-1:0]   prod_r;
  logic [ald_pkg::LEVEL_W-1:0]  level_r, level_nxt;
  logic                         cal_frame_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [ald_pkg::LEVEL_W-1:0]  out_level_r;
  logic                         out_ind_r;
  logic                         out_cal_r;
  logic [ald_pkg::MEAN_W-1:0]   out_noise_r;

  logic [ald_pkg::SAMPLE_W-1:0] raw;
  logic [ald_pkg::SAMPLE_W-1:0] mag;
  logic [DIV_W-1:0]             dvd;
  logic [DVS_W-1:0]             dvs;
  logic                         div_done;
  logic [DIV_W-1:0]             quo;
  logic [DIV_W-1:0]             excess;
  logic [ald_pkg::LEVEL_W-1:0]  level_calc;
  logic [ald_pkg::CFC_W-1:0]    eff_frames;

  // magnitude; the most negative sample maps to 32768
  assign raw = in_sample;
  assign mag = raw[ald_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    priority if (cmd.clear_frame) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.accept && (cnt_r < CNT_W'(MAX_FRAME_SAMPLES))) begin
      sum_nxt = sum_r + SUM_W'(mag);
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      sum_nxt = sum_r;
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      ald_pkg::DIV_MEAN: begin
        dvd = DIV_W'(sum_r);
        dvs = DVS_W'(cnt_r);
      end
      ald_pkg::DIV_FLOOR: begin
        dvd = DIV_W'(nacc_r);
        dvs = DVS_W'(cfc_r);
      end
      ald_pkg::DIV_LEVEL: begin
        dvd = DIV_W'(prod_r);
        dvs = floor_r;
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  ald_divider #(
    .DIV_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // percent above floor, saturated
  assign excess = quo - DIV_W'(ald_pkg::PCT_SCALE);
  always_comb begin
    priority if (quo <= DIV_W'(ald_pkg::PCT_SCALE)) begin
      level_calc = '0;
    end else if (excess > DIV_W'(ald_pkg::LEVEL_CAP)) begin
      level_calc = ald_pkg::LEVEL_CAP;
    end else begin
      level_calc = excess[ald_pkg::LEVEL_W-1:0];
    end
  end

  // a register value of zero counts as one frame
  assign eff_frames = (calib_len == '0) ? ald_pkg::CFC_W'(1) : calib_len;

  always_comb begin
    nacc_nxt     = nacc_r;
    cfc_nxt      = cfc_r;
    floor_nxt    = floor_r;
    cal_done_nxt = cal_done_r;
    level_nxt    = level_r;
    ind_nxt      = ind_r;
    if (cmd.cal_update) begin
      nacc_nxt = nacc_r + ald_pkg::ACC_W'(mean_r);
      cfc_nxt  = cfc_r + 1'b1;
    end
    if (cmd.latch_floor) begin
      floor_nxt    = (quo[ald_pkg::MEAN_W-1:0] == '0) ? ald_pkg::MEAN_W'(1)
                                                      : quo[ald_pkg::MEAN_W-1:0];
      cal_done_nxt = 1'b1;
    end
    priority if (cmd.clear_frame) begin
      level_nxt = '0;
    end else if (cmd.latch_level) begin
      level_nxt = level_calc;
    end else begin
      level_nxt = level_r;
    end
    if (cmd.update_ind) begin
      priority if (!ind_r && (level_r > on_thr)) begin
        ind_nxt = 1'b1;
      end else if (ind_r && (level_r < off_thr)) begin
        ind_nxt = 1'b0;
      end else begin
        ind_nxt = ind_r;
      end
    end
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    if (cmd.latch_mean) mean_r <= quo[ald_pkg::MEAN_W-1:0];
    if (cmd.latch_prod) prod_r <= ald_pkg::PROD_W'(mean_r) * ald_pkg::PROD_W'(ald_pkg::PCT_SCALE);
    if (cmd.clear_frame) cal_frame_r <= ~cal_done_r;
    if (cmd.load_out) begin
      out_level_r <= level_r;
      out_ind_r   <= ind_r;
      out_cal_r   <= cal_frame_r;
      out_noise_r <= floor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      nacc_r      <= '0;
      cfc_r       <= '0;
      floor_r     <= '0;
      cal_done_r  <= 1'b0;
      ind_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      nacc_r      <= nacc_nxt;
      cfc_r       <= cfc_nxt;
      floor_r     <= floor_nxt;
      cal_done_r  <= cal_done_nxt;
      ind_r       <= ind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    sts.div_done      = div_done;
    sts.cal_done      = cal_done_r;
    sts.cal_reached   = (cfc_r >= eff_frames);
    sts.mean_gt_floor = (mean_r > floor_r);
    sts.out_busy      = out_valid_r & out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_level_percent = out_level_r;
  assign out_indicator_on  = out_ind_r;
  assign out_calibrating   = out_cal_r;
  assign out_noise_level   = out_noise_r;

endmodule

// File: rtl/core/audio_level_detector.sv
// top level of the audio level detector: register port, sequencer and datapath
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in_      | in_valid / in_stall       | in_sample (s16), in_frame_last
//  out_     | out_valid / out_stall     | out_level_percent, out_indicator_on,
//           |                           | out_calibrating, out_noise_level
//  cfg      | psel penable pwrite pready| paddr, pwdata, prdata (word regs at 0, 4, 8)
//
// samples without the frame mark stream at one per clock while no frame-end transaction holds in_stall
// a frame-end transaction runs the shared bit-serial divider for the mean, then where needed for
//   the floor or the level: DIV_W = max(clog2(MAX_FRAME_SAMPLES+1) + 15, 24), 25 at the default size;
//   calibration frames that do not close calibration skip the second division
// in_stall is high from the frame-end transaction until its result is in the output reg
// a finished result waits in the output register under out_stall while samples keep
//   flowing; only the next frame end waits for it to be taken
// rst_n is synchronous; no clearing pass is needed, all control state resets at once
module audio_level_detector #(
  parameter int MAX_FRAME_SAMPLES = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ald_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_frame_last,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ald_pkg::LEVEL_W-1:0]         out_level_percent,
  output logic                                out_indicator_on,
  output logic                                out_calibrating,
  output logic [ald_pkg::MEAN_W-1:0]          out_noise_level,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ald_pkg::ADDR_W-1:0]          paddr,
  input  logic [ald_pkg::DATA_W-1:0]          pwdata,
  output logic [ald_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  // configuration registers
  logic [ald_pkg::THR_W-1:0] on_thr_r, on_thr_nxt;
  logic [ald_pkg::THR_W-1:0] off_thr_r, off_thr_nxt;
  logic [ald_pkg::CFC_W-1:0] calib_len_r, calib_len_nxt;
  logic                      wr_en;
  logic [1:0]                reg_idx;

  ald_pkg::ctrl_cmd_t cmd;
  ald_pkg::ctrl_sts_t sts;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // write decode; unmapped addresses are dropped
  always_comb begin
    on_thr_nxt    = on_thr_r;
    off_thr_nxt   = off_thr_r;
    calib_len_nxt = calib_len_r;
    if (wr_en) begin
      unique case (reg_idx)
        ald_pkg::REG_ON_THR:    on_thr_nxt    = pwdata[ald_pkg::THR_W-1:0];
        ald_pkg::REG_OFF_THR:   off_thr_nxt   = pwdata[ald_pkg::THR_W-1:0];
        ald_pkg::REG_CALIB_LEN: calib_len_nxt = pwdata[ald_pkg::CFC_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      ald_pkg::REG_ON_THR:    prdata = ald_pkg::DATA_W'(on_thr_r);
      ald_pkg::REG_OFF_THR:   prdata = ald_pkg::DATA_W'(off_thr_r);
      ald_pkg::REG_CALIB_LEN: prdata = ald_pkg::DATA_W'(calib_len_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thr_r    <= ald_pkg::ON_THR_RST;
      off_thr_r   <= ald_pkg::OFF_THR_RST;
      calib_len_r <= ald_pkg::CALIB_LEN_RST;
    end else begin
      on_thr_r    <= on_thr_nxt;
      off_thr_r   <= off_thr_nxt;
      calib_len_r <= calib_len_nxt;
    end
  end

  // sequencer: takes samples, walks the frame-end steps
  ald_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_last (in_frame_last),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // datapath: running sum, calibration, level, hysteresis, output register
  ald_datapath #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample         (in_sample),
    .on_thr            (on_thr_r),
    .off_thr           (off_thr_r),
    .calib_len         (calib_len_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_level_percent (out_level_percent),
    .out_indicator_on  (out_indicator_on),
    .out_calibrating   (out_calibrating),
    .out_noise_level   (out_noise_level)
  );

endmodule

// File: rtl/core/ald_checker.sv
// port-level checks of the audio level detector and their binding
module ald_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_frame_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_level_percent,
  input logic        out_indicator_on,
  input logic        out_calibrating,
  input logic [15:0] out_noise_level
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level_percent) &&
      $stable(out_indicator_on) && $stable(out_calibrating) && $stable(out_noise_level))
    else $error("result changed while stalled");

  // calibration frames report no level and a dark indicator
  a_cal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_calibrating |-> out_level_percent == 10'd0 && !out_indicator_on)
    else $error("level or indicator set in a calibration frame");

  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_percent <= 10'd1000)
    else $error("level above saturation");

  // after calibration the floor is at least one
  a_floor_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_calibrating |-> out_noise_level != 16'd0)
    else $error("zero noise floor after calibration");

  // a frame-end transaction holds off the next sample
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_frame_last |=> in_stall)
    else $error("input taken during frame-end processing");

endmodule

bind audio_level_detector ald_checker u_ald_checker (.*);

// File: sim/tb_top.sv
// self-checking bench for audio_level_detector: directed and random frames against a frame predictor
module tb_top;

  localparam int MAX_FRAME    = 512;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // a frame end runs through the shared divider, so this covers it with margin
  localparam int SETTLE       = 100;
  localparam int RANDOM_ITEMS = 90;
  localparam int PCT          = 100;
  localparam int LEVEL_MAX    = 1000;

  // what the block reports at the end of one frame
  typedef struct {
    logic [ald_pkg::LEVEL_W-1:0] level;
    logic                        ind;
    logic                        cal;
    logic [ald_pkg::MEAN_W-1:0]  noise;
  } level_report_t;

  logic                                clk           = 1'b0;
  logic                                rst_n         = 1'b0;
  logic                                in_valid      = 1'b0;
  logic                                in_stall;
  logic signed [ald_pkg::SAMPLE_W-1:0] in_sample     = '0;
  logic                                in_frame_last = 1'b0;
  logic                                out_valid;
  logic                                out_stall     = 1'b0;
  logic [ald_pkg::LEVEL_W-1:0]         out_level_percent;
  logic                                out_indicator_on;
  logic                                out_calibrating;
  logic [ald_pkg::MEAN_W-1:0]          out_noise_level;
  logic                                psel          = 1'b0;
  logic                                penable       = 1'b0;
  logic                                pwrite        = 1'b0;
  logic [ald_pkg::ADDR_W-1:0]          paddr         = '0;
  logic [ald_pkg::DATA_W-1:0]          pwdata        = '0;
  logic [ald_pkg::DATA_W-1:0]          prdata;
  logic                                pready;

  // idle percentages of the sender and the receiver, changed between phases
  int in_gap_pct    = 18;
  int out_stall_pct = 67;
  int errors        = 0;
  int cycle_count   = 0;

  // predictor state: frame accumulation, calibration and indicator
  logic [24:0]               frame_abs_sum = '0;
  int unsigned               frame_samples = 0;
  logic [23:0]               cal_mean_sum  = '0;
  logic [7:0]                calib_seen    = '0;
  logic [15:0]               floor_est     = '0;
  bit                        floor_ready   = 1'b0;
  bit                        led_state     = 1'b0;
  // register shadows, start at their reset values
  logic [ald_pkg::THR_W-1:0] on_thr_sh     = ald_pkg::ON_THR_RST;
  logic [ald_pkg::THR_W-1:0] off_thr_sh    = ald_pkg::OFF_THR_RST;
  logic [ald_pkg::CFC_W-1:0] calib_len_sh  = ald_pkg::CALIB_LEN_RST;

  level_report_t level_reports_q[$];

  audio_level_detector #(
    .MAX_FRAME_SAMPLES(MAX_FRAME)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_frame_last    (in_frame_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_percent(out_level_percent),
    .out_indicator_on (out_indicator_on),
    .out_calibrating  (out_calibrating),
    .out_noise_level  (out_noise_level),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver back-pressure at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  // advance the predictor by one accepted sample; a frame end queues one report
  task automatic predict_frame_report(input logic signed [ald_pkg::SAMPLE_W-1:0] s,
                                      input logic last);
    int               sv;
    int unsigned      mag;
    int unsigned      mean;
    int unsigned      fl;
    longint unsigned  ratio;
    int unsigned      level;
    level_report_t    r;
    sv    = s;
    mag   = (sv < 0) ? -sv : sv;
    level = 0;
    r.cal = 1'b0;
    // samples past the frame size are dropped, but the frame still ends on the mark
    if (frame_samples < MAX_FRAME) begin
      frame_abs_sum += 25'(mag);
      frame_samples++;
    end
    if (!last) return;
    mean          = frame_abs_sum / frame_samples;
    frame_abs_sum = '0;
    frame_samples = 0;
    if (!floor_ready) begin
      // calibration frame: fold the mean in, close once the count reaches the register
      r.cal         = 1'b1;
      cal_mean_sum += 24'(mean);
      calib_seen   += 8'd1;
      if (calib_seen >= calib_len_sh) begin
        fl = cal_mean_sum / ((calib_seen != 0) ? calib_seen : 8'd1);
        if (fl < 1) fl = 1;
        floor_est   = 16'(fl);
        floor_ready = 1'b1;
      end
    end else begin
      if (floor_est != 0 && mean > floor_est) begin
        ratio = (longint'(mean) * PCT) / floor_est;
        if (ratio > PCT) level = (ratio - PCT > LEVEL_MAX) ? LEVEL_MAX : int'(ratio - PCT);
      end
      // on/off hysteresis
      if (!led_state && level > on_thr_sh) led_state = 1'b1;
      else if (led_state && level < off_thr_sh) led_state = 1'b0;
    end
    r.level = ald_pkg::LEVEL_W'(level);
    r.ind   = led_state;
    r.noise = floor_est;
    level_reports_q.push_back(r);
  endtask

  // compare every accepted result with the oldest queued report
  always @(posedge clk) begin : check_reports
    level_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (level_reports_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual level %0d ind %0d cal %0d noise %0d",
                 $time, out_level_percent, out_indicator_on, out_calibrating, out_noise_level);
      end else begin
        want = level_reports_q.pop_front();
        check_field("level_percent", want.level, out_level_percent);
        check_field("indicator_on", want.ind, out_indicator_on);
        check_field("calibrating", want.cal, out_calibrating);
        check_field("noise_level", want.noise, out_noise_level);
      end
    end
  end

  // one register transaction: setup phase, access phase, then back to idle
  task automatic reg_access(input bit wr, input logic [1:0] idx,
                            input logic [ald_pkg::DATA_W-1:0] wdata,
                            output logic [ald_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    pwrite  <= wr;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [ald_pkg::DATA_W-1:0] rd;
    logic [ald_pkg::DATA_W-1:0] want;
    reg_access(1'b0, idx, '0, rd);
    case (idx)
      ald_pkg::REG_ON_THR:    want = ald_pkg::DATA_W'(on_thr_sh);
      ald_pkg::REG_OFF_THR:   want = ald_pkg::DATA_W'(off_thr_sh);
      ald_pkg::REG_CALIB_LEN: want = ald_pkg::DATA_W'(calib_len_sh);
      default:                want = '0;
    endcase
    check_field("register read", want, rd);
  endtask

  // write, update the shadow, read back
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    logic [ald_pkg::DATA_W-1:0] rd;
    reg_access(1'b1, idx, ald_pkg::DATA_W'(val), rd);
    case (idx)
      ald_pkg::REG_ON_THR:    on_thr_sh    = ald_pkg::THR_W'(val);
      ald_pkg::REG_OFF_THR:   off_thr_sh   = ald_pkg::THR_W'(val);
      ald_pkg::REG_CALIB_LEN: calib_len_sh = ald_pkg::CFC_W'(val);
      default: ;
    endcase
    check_reg(idx);
  endtask

  // one sample transaction; valid stays high into the next call unless the sender idles
  task automatic send_sample(input logic signed [ald_pkg::SAMPLE_W-1:0] s, input logic last);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_frame_last <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_frame_report(s, last);
  endtask

  // stop sending until every queued report has come, then let the block settle
  task automatic wait_reports_drained(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (level_reports_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic test_register_defaults();
    check_reg(ald_pkg::REG_ON_THR);
    check_reg(ald_pkg::REG_OFF_THR);
    check_reg(ald_pkg::REG_CALIB_LEN);
  endtask

  // three calibration frames with means 0, 75 and 40: floor is 115/3 = 38
  task automatic test_calibration();
    write_reg(ald_pkg::REG_CALIB_LEN, 255);
    send_sample(16'sd0, 1'b1);
    wait_reports_drained(SETTLE);
    write_reg(ald_pkg::REG_CALIB_LEN, 5);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd50, 1'b1);
    wait_reports_drained(SETTLE);
    // zero acts as one and, lowered mid-calibration, closes it on the next frame
    write_reg(ald_pkg::REG_CALIB_LEN, 0);
    send_sample(16'sd41, 1'b0);
    send_sample(-16'sd40, 1'b0);
    send_sample(16'sd39, 1'b1);
  endtask

  task automatic test_level_hysteresis();
    wait_reports_drained(SETTLE);
    // after calibration the frame count register must not move the floor
    write_reg(ald_pkg::REG_CALIB_LEN, 1);
    write_reg(ald_pkg::REG_ON_THR, 20);
    write_reg(ald_pkg::REG_OFF_THR, 10);
    send_sample(16'sd32767, 1'b1);    // saturates, indicator on
    send_sample(-16'sd32768, 1'b1);   // largest magnitude
    send_sample(16'sd38, 1'b1);       // equal to floor, level 0, off
    send_sample(16'sd39, 1'b1);       // level 2
    send_sample(16'sd46, 1'b1);       // level 21, just over on
    send_sample(16'sd42, 1'b1);       // level 10, not under off, stays on
    send_sample(16'sd41, 1'b1);       // level 7, off
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd1, 1'b0);       // mean 3/2 truncates to 1
    send_sample(16'sd2, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    wait_reports_drained(SETTLE);
    // on threshold above the level cap never turns on
    write_reg(ald_pkg::REG_ON_THR, 1023);
    write_reg(ald_pkg::REG_OFF_THR, 0);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    wait_reports_drained(SETTLE);
    // any level above zero turns on, any level under 1023 turns off again
    write_reg(ald_pkg::REG_ON_THR, 0);
    write_reg(ald_pkg::REG_OFF_THR, 1023);
    send_sample(16'sd39, 1'b1);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd39, 1'b1);
    wait_reports_drained(SETTLE);
    write_reg(ald_pkg::REG_ON_THR, 999);
    write_reg(ald_pkg::REG_OFF_THR, 999);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd38, 1'b1);
  endtask

  task automatic test_long_frames();
    wait_reports_drained(SETTLE);
    write_reg(ald_pkg::REG_ON_THR, 100);
    write_reg(ald_pkg::REG_OFF_THR, 50);
    // a full frame of the largest magnitude needs all 25 bits of the sum
    for (int i = 0; i < MAX_FRAME; i++) send_sample(-16'sd32768, 1'b0);
    // overlong frame: random samples past the frame size, end mark among them, must not count
    for (int i = 0; i < 7; i++) send_sample(ald_pkg::SAMPLE_W'($urandom), i == 6);
  endtask

  // frame of random length and loudness; most frames short
  task automatic send_random_frame(output int n);
    int amp;
    int mode;
    n    = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
    mode = $urandom_range(0, 9);
    amp  = (mode < 5) ? $urandom_range(0, 700) : (mode < 8) ? $urandom_range(0, 60) : 0;
    for (int i = 0; i < n; i++) begin
      if (mode >= 8) send_sample(ald_pkg::SAMPLE_W'($urandom), i == n - 1);
      else send_sample(ald_pkg::SAMPLE_W'($urandom_range(0, 2 * amp) - amp), i == n - 1);
    end
  endtask

  task automatic test_random_traffic();
    int  sent;
    int  n;
    bit  paused;
    for (int ph = 0; ph < 3; ph++) begin
      wait_reports_drained(SETTLE);
      case (ph)
        0: begin
          in_gap_pct    = 18;
          out_stall_pct = 67;
        end
        1: begin
          in_gap_pct    = 67;
          out_stall_pct = 18;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      write_reg(ald_pkg::REG_ON_THR, $urandom_range(0, 400));
      write_reg(ald_pkg::REG_OFF_THR, $urandom_range(0, 400));
      write_reg(ald_pkg::REG_CALIB_LEN, $urandom_range(0, 255));
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS / 3) begin
        send_random_frame(n);
        sent += n;
        // sender holds off mid-phase until the block has emptied out
        if (ph == 1 && !paused && sent >= RANDOM_ITEMS / 6) begin
          wait_reports_drained(0);
          paused = 1'b1;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_calibration();
    test_level_hysteresis();
    test_threshold_extremes();
    test_long_frames();
    test_random_traffic();
    wait_reports_drained(SETTLE);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
